// ----- design/mifs_pkg.sv -----
`default_nettype none
package mifs_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 32;
   localparam int COMP_W   = 1 + KEY_W + IDX_W;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
      logic        last;
   } req_word_type;

   typedef struct packed {
      logic        kind_res;
      logic [31:0] value_res;
      logic        last_res;
      logic        overflow;
   } rsp_word_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] value;
   } entry_type;

   typedef struct packed {
      entry_type entry;
      logic      last;
   } sel_word_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] count;
   } scan_ctrl_type;

   // Unsigned key whose ascending order is the output order within one kind.
   function automatic logic [KEY_W-1:0] order_key(input entry_type e);
      logic [KEY_W-1:0] key;
      if (!e.kind) begin
         key = ~(e.value ^ 32'h8000_0000);
      end else if (e.value[31]) begin
         key = ~e.value;
      end else begin
         key = e.value | 32'h8000_0000;
      end
      return key;
   endfunction

endpackage
`default_nettype wire

// ----- design/mifs_store.sv -----
`default_nettype none
module mifs_store
   import mifs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [IDX_W-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic             rd_en,
   input  wire logic [IDX_W-1:0] rd_addr,
   output entry_type             rd_data
);

   entry_type store_mem [CAPACITY];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- design/mifs_scan.sv -----
`default_nettype none
module mifs_scan
   import mifs_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire scan_ctrl_type    ctrl,
   output logic                  rd_en,
   output logic [IDX_W-1:0]      rd_addr,
   input  wire entry_type        rd_data,
   output logic                  sel_valid,
   output sel_word_type          sel_word,
   input  wire logic             sel_ready
);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_HOLD} state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] n_ff;
   logic [CNT_W-1:0] addr_ff;
   logic [CNT_W-1:0] round_ff;
   logic             data_vld_ff;
   logic [IDX_W-1:0] data_idx_ff;
   logic [COMP_W-1:0] prev_ff;
   logic             have_prev_ff;
   logic [COMP_W-1:0] best_ff;
   entry_type        best_entry_ff;
   logic             have_best_ff;

   logic [COMP_W-1:0] cand_comp;
   logic              cand_ok;
   logic              cand_take;
   logic              final_round;

   assign cand_comp   = {rd_data.kind, order_key(rd_data), data_idx_ff};
   assign cand_ok     = data_vld_ff && (!have_prev_ff || (cand_comp > prev_ff));
   assign cand_take   = cand_ok && (!have_best_ff || (cand_comp < best_ff));
   assign final_round = (round_ff == (n_ff - CNT_W'(1)));

   assign rd_en   = (state_ff == S_SCAN) && (addr_ff < n_ff);
   assign rd_addr = addr_ff[IDX_W-1:0];

   assign sel_valid      = (state_ff == S_HOLD);
   assign sel_word.entry = best_entry_ff;
   assign sel_word.last  = final_round;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         data_vld_ff  <= 1'b0;
         have_prev_ff <= 1'b0;
         have_best_ff <= 1'b0;
         n_ff         <= '0;
         addr_ff      <= '0;
         round_ff     <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               data_vld_ff <= 1'b0;
               if (ctrl.start) begin
                  n_ff         <= ctrl.count;
                  addr_ff      <= '0;
                  round_ff     <= '0;
                  have_prev_ff <= 1'b0;
                  have_best_ff <= 1'b0;
                  state_ff     <= S_SCAN;
               end
            end
            S_SCAN: begin
               data_vld_ff <= rd_en;
               data_idx_ff <= addr_ff[IDX_W-1:0];
               if (rd_en) begin
                  addr_ff <= addr_ff + CNT_W'(1);
               end
               if (cand_take) begin
                  best_ff       <= cand_comp;
                  best_entry_ff <= rd_data;
                  have_best_ff  <= 1'b1;
               end
               if (!rd_en && !data_vld_ff) begin
                  state_ff <= S_HOLD;
               end
            end
            S_HOLD: begin
               data_vld_ff <= 1'b0;
               if (sel_ready) begin
                  prev_ff      <= best_ff;
                  have_prev_ff <= 1'b1;
                  have_best_ff <= 1'b0;
                  round_ff     <= round_ff + CNT_W'(1);
                  addr_ff      <= '0;
                  state_ff     <= final_round ? S_IDLE : S_SCAN;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule
`default_nettype wire

// ----- design/mixed_int_float_sorter_top.sv -----
`default_nettype none
// Collects a set of tagged numbers and returns them sorted.
// The req channel takes one word per cycle while the block is collecting;
// each word holds a kind (0 signed integer, 1 single float), a raw 32-bit
// value and a last mark. Up to 64 numbers are stored; later ones are dropped
// and every result of that set carries the overflow mark.
// The word marked last starts the output burst on the rsp channel: integers
// in descending signed order, then floats in ascending order, equal keys in
// arrival order, last_res on the final word of the set. req_ready is low
// from the last word until the final result has entered the output register.
// Each result is found by one pass over the store memory, one entry read per
// cycle, so a set of n stored numbers takes n passes; the single read port of
// the store sets this. Collection runs at one word per cycle.
// A stalled receiver holds the current result in the output register and the
// next result waits in the scan unit until the register frees.
// Reset empties the store count, clears the overflow mark and any pending
// result; the store contents themselves are not cleared.
module mixed_int_float_sorter_top
   import mifs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   typedef enum logic {M_COLLECT, M_EMIT} mode_type;

   mode_type         mode_ff;
   mode_type         mode_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             dropped_ff;
   logic             dropped_in;
   logic             set_ovf_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_word_type     rsp_word_ff;

   logic             req_acc;
   logic             has_room;
   logic             wr_en;
   entry_type        wr_data;
   entry_type        rd_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   scan_ctrl_type    scan_ctrl;
   logic             sel_valid;
   logic             sel_ready;
   sel_word_type     sel_word;
   logic             load;
   logic [CNT_W-1:0] count_next;
   logic             dropped_next;

   assign req_ready = (mode_ff == M_COLLECT);
   assign req_acc   = req_valid && req_ready;
   assign has_room  = (count_ff < CNT_W'(CAPACITY));
   assign wr_en     = req_acc && has_room;
   assign wr_data   = '{kind: req_word.kind, value: req_word.value};

   assign count_next   = has_room ? (count_ff + CNT_W'(1)) : count_ff;
   assign dropped_next = dropped_ff || !has_room;

   assign scan_ctrl.start = req_acc && req_word.last;
   assign scan_ctrl.count = count_next;

   assign sel_ready    = !rsp_valid_ff || rsp_ready;
   assign load         = sel_valid && sel_ready;
   assign rsp_valid_in = load || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      mode_in    = mode_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (req_acc) begin
         if (req_word.last) begin
            count_in   = '0;
            dropped_in = 1'b0;
            mode_in    = M_EMIT;
         end else begin
            count_in   = count_next;
            dropped_in = dropped_next;
         end
      end
      if (load && sel_word.last) begin
         mode_in = M_COLLECT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= M_COLLECT;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         set_ovf_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         if (scan_ctrl.start) begin
            set_ovf_ff <= dropped_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_word_ff.kind_res  <= sel_word.entry.kind;
         rsp_word_ff.value_res <= sel_word.entry.value;
         rsp_word_ff.last_res  <= sel_word.last;
         rsp_word_ff.overflow  <= set_ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   mifs_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mifs_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (scan_ctrl),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .sel_valid (sel_valid),
      .sel_word  (sel_word),
      .sel_ready (sel_ready)
   );

endmodule
`default_nettype wire

// ----- design/mifs_checker.sv -----
`default_nettype none
module mifs_checker
   import mifs_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_valid,
   input wire logic         req_ready,
   input wire req_word_type req_word,
   input wire logic         rsp_valid,
   input wire logic         rsp_ready,
   input wire rsp_word_type rsp_word
);

   // A stalled result stays in place.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // Collection stops only after a last word was taken.
   a_ready_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid && req_ready && req_word.last))
      else $error("req_ready dropped without a last word");

   // The final result of a set reopens collection as it appears.
   a_last_reopens: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_word.last_res |-> req_ready)
      else $error("collection not reopened with final result");

   // No result is present in the first cycle after reset.
   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result present right after reset");

endmodule

bind mixed_int_float_sorter_top mifs_checker u_mifs_checker (.*);
`default_nettype wire

// ----- test/mixed_int_float_sorter_order_checker.sv -----
`timescale 1ns / 100ps
module mixed_int_float_sorter_order_checker
   import mifs_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   input  wire logic         req_ready,
   input  wire req_word_type req_word,
   input  wire logic         rsp_valid,
   input  wire logic         rsp_ready,
   input  wire rsp_word_type rsp_word,
   output int                order_errors,
   output int                words_awaited
);

   entry_type    held_set[$];
   logic         set_dropped;
   rsp_word_type sorted_words[$];

   initial begin
      order_errors  = 0;
      words_awaited = 0;
      set_dropped   = 1'b0;
   end

   // Negative floats count down in magnitude, positive floats count up.
   function automatic logic [31:0] float_rank(input logic [31:0] bits);
      return bits[31] ? ~bits : {1'b1, bits[30:0]};
   endfunction

   function automatic bit emits_first(input entry_type a, input entry_type b);
      if (a.kind != b.kind) begin
         return !a.kind;
      end
      if (!a.kind) begin
         return $signed(a.value) > $signed(b.value);
      end
      return float_rank(a.value) < float_rank(b.value);
   endfunction

   // Stable insertion: a new entry goes behind every entry it does not precede.
   function automatic void release_set();
      entry_type    ordered[$];
      rsp_word_type w;
      int           j;
      foreach (held_set[i]) begin
         j = 0;
         while (j < ordered.size() && !emits_first(held_set[i], ordered[j])) begin
            j++;
         end
         ordered.insert(j, held_set[i]);
      end
      foreach (ordered[k]) begin
         w.kind_res  = ordered[k].kind;
         w.value_res = ordered[k].value;
         w.last_res  = (k == ordered.size() - 1);
         w.overflow  = set_dropped;
         sorted_words.push_back(w);
      end
      held_set.delete();
      set_dropped = 1'b0;
   endfunction

   always @(posedge clock) begin
      entry_type    e;
      rsp_word_type want;
      if (reset) begin
         held_set.delete();
         sorted_words.delete();
         set_dropped = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            e.kind  = req_word.kind;
            e.value = req_word.value;
            if (held_set.size() < CAPACITY) begin
               held_set.push_back(e);
            end else begin
               set_dropped = 1'b1;
            end
            if (req_word.last) begin
               release_set();
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (sorted_words.size() == 0) begin
               order_errors++;
               $display("%0t: unexpected word: kind %0d value %h last %0d overflow %0d",
                        $time, rsp_word.kind_res, rsp_word.value_res, rsp_word.last_res,
                        rsp_word.overflow);
            end else begin
               want = sorted_words.pop_front();
               if (rsp_word.kind_res !== want.kind_res ||
                   rsp_word.value_res !== want.value_res ||
                   rsp_word.last_res !== want.last_res ||
                   rsp_word.overflow !== want.overflow) begin
                  order_errors++;
                  $display("%0t: mismatch: expected kind %0d value %h last %0d overflow %0d",
                           $time, want.kind_res, want.value_res, want.last_res,
                           want.overflow);
                  $display("%0t:                got kind %0d value %h last %0d overflow %0d",
                           $time, rsp_word.kind_res, rsp_word.value_res,
                           rsp_word.last_res, rsp_word.overflow);
               end
            end
         end
      end
      words_awaited <= sorted_words.size();
   end

endmodule

// ----- test/mixed_int_float_sorter_top_test.sv -----
`timescale 1ns / 100ps
module mixed_int_float_sorter_top_test;
   import mifs_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 100;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   int order_errors;
   int words_awaited;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request  = 1'b0;

   mixed_int_float_sorter_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   mixed_int_float_sorter_order_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_word      (rsp_word),
      .order_errors  (order_errors),
      .words_awaited (words_awaited)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_word(input logic kind, input logic [31:0] value, input logic last);
      req_word_type w;
      w.kind  = kind;
      w.value = value;
      w.last  = last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [31:0] pick_value(input logic [31:0] prev);
      logic [31:0] specials [10] = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'hFFFF_FFFF, 32'h7F80_0000, 32'hFF80_0000,
                                     32'h7FC0_0000, 32'hFFC0_0000, 32'h0000_0001,
                                     32'h8000_0001};
      case ($urandom_range(5))
         0: begin
            return specials[$urandom_range(9)];
         end
         1: begin
            return prev;
         end
         2: begin
            return $urandom_range(1) ? 32'($urandom_range(15)) : -32'($urandom_range(15));
         end
         default: begin
            return $urandom;
         end
      endcase
   endfunction

   task automatic send_set(input int size);
      logic [31:0] prev;
      prev = $urandom;
      for (int k = 0; k < size; k++) begin
         prev = pick_value(prev);
         send_word(1'($urandom_range(1)), prev, k == size - 1);
      end
   endtask

   task automatic send_short_sets(input int budget);
      int sent;
      int size;
      sent = 0;
      while (sent < budget) begin
         size = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
         send_set(size);
         sent += size;
      end
   endtask

   // Receiver: random backpressure, with one long hold-off on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 35;
      recv_idle_pct = 65;
      send_word(1'b0, 32'h1234_5678, 1'b1);
      send_word(1'b0, 32'h7FFF_FFFF, 1'b0);
      send_word(1'b1, 32'h0000_0000, 1'b0);
      send_word(1'b0, 32'h8000_0000, 1'b0);
      send_word(1'b1, 32'h8000_0000, 1'b0);
      send_word(1'b0, 32'h0000_0000, 1'b0);
      send_word(1'b1, 32'h7F80_0000, 1'b0);
      send_word(1'b0, 32'hFFFF_FFFF, 1'b0);
      send_word(1'b1, 32'hFF80_0000, 1'b0);
      send_word(1'b1, 32'h7FC0_0000, 1'b0);
      send_word(1'b0, 32'h0000_0001, 1'b0);
      send_word(1'b1, 32'hFFC0_0000, 1'b0);
      send_word(1'b0, 32'hFFFF_FFFF, 1'b0);
      send_word(1'b1, 32'h0000_0001, 1'b0);
      send_word(1'b1, 32'h8000_0001, 1'b0);
      send_word(1'b1, 32'h7F7F_FFFF, 1'b0);
      send_word(1'b1, 32'h3F80_0000, 1'b0);
      send_word(1'b1, 32'hBF80_0000, 1'b0);
      send_word(1'b1, 32'hFFFF_FFFF, 1'b0);
      send_word(1'b0, 32'h0000_0080, 1'b1);
      send_word(1'b1, 32'h4000_0000, 1'b0);
      send_word(1'b1, 32'hC000_0000, 1'b1);
      send_short_sets(25);

      send_idle_pct = 65;
      recv_idle_pct = 35;
      send_set(CAPACITY + 2);
      send_short_sets(25);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      send_short_sets(25);
      send_set(CAPACITY);
      req_valid <= 1'b0;

      do @(posedge clock); while (words_awaited != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (order_errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
